// ===== src/bpp_pkg.sv =====
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared widths, types and fixed-point helpers for the Boris particle push.
// ----------------------------------------------------------------------------
`default_nettype none

package bpp_pkg;

  localparam int FRAC_BITS = 24;
  localparam int WORD_BITS = 32;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int XW = W + 2;      // multiplier operand width
  localparam int PW = 2 * XW;     // product magnitude width
  localparam int SW = W + 3;      // width of small exact sums
  localparam int QB = W + 1;      // quotient bits

  typedef logic signed [W-1:0]  word_t;
  typedef logic signed [XW-1:0] xword_t;
  typedef logic signed [SW-1:0] sword_t;
  typedef logic [PW-1:0]        prod_t;

  typedef struct packed {
    logic  neg;
    prod_t mag;
  } mres_t;

  typedef struct packed {
    logic [2:0][W-1:0] pos;
    word_t [2:0]       vel;
    word_t [2:0]       e;
    word_t [2:0]       b;
  } part_t;

  typedef struct packed {
    logic [2:0][W-1:0] pos;
    word_t [2:0]       vm;
    word_t [2:0]       he;
    word_t [2:0]       vp;
  } side_t;

  typedef struct packed {
    logic [W:0] nmag;
    logic       neg;
  } dreq_t;

  typedef enum logic [2:0] {
    CFG_TIME_STEP = 3'd0,
    CFG_CMR       = 3'd1,
    CFG_LEN_X     = 3'd2,
    CFG_LEN_Y     = 3'd3,
    CFG_LEN_Z     = 3'd4
  } cfg_reg_t;

  localparam word_t WMAX_C = {1'b0, {(W-1){1'b1}}};
  localparam word_t WMIN_C = {1'b1, {(W-1){1'b0}}};
  localparam sword_t SMAX_C = SW'(WMAX_C);
  localparam sword_t SMIN_C = SW'(WMIN_C);
  localparam logic [W-1:0] ONE_C = W'(1) << F;

  localparam logic [W-2:0] TS_RST  = (W-1)'(167772);
  localparam logic [W-1:0] CMR_RST = W'(0) - ONE_C;
  localparam logic [W-1:0] LEN_RST = W'(16) << F;

  // neighbor axes for cross products
  localparam int NXA [3] = '{1, 2, 0};
  localparam int NXB [3] = '{2, 0, 1};

  function automatic xword_t xw(word_t w);
    return XW'(w);
  endfunction

  function automatic sword_t sx(word_t w);
    return SW'(w);
  endfunction

  function automatic word_t sat_s(sword_t x);
    if (x > SMAX_C) return WMAX_C;
    else if (x < SMIN_C) return WMIN_C;
    else return x[W-1:0];
  endfunction

  function automatic mres_t fmul_mag(xword_t a, xword_t b);
    logic [XW-1:0] ma;
    logic [XW-1:0] mb;
    mres_t r;
    ma = a[XW-1] ? XW'(-a) : XW'(a);
    mb = b[XW-1] ? XW'(-b) : XW'(b);
    r.neg = a[XW-1] ^ b[XW-1];
    r.mag = PW'(ma) * PW'(mb);
    return r;
  endfunction

  // round half away from zero, shift, saturate
  function automatic word_t rnd_sat(mres_t m, int sh);
    prod_t r;
    r = (m.mag + (prod_t'(1) << (sh - 1))) >> sh;
    if (r >= (prod_t'(1) << (W - 1))) return m.neg ? WMIN_C : WMAX_C;
    else if (m.neg) return word_t'(-r[W-1:0]);
    else return word_t'(r[W-1:0]);
  endfunction

endpackage

`default_nettype wire

// ===== src/boris_particle_push.sv =====
// Throughput: one item per cycle unless the output stalls. Items pass through
// bpp_front, bpp_div and bpp_fin; the divider is a one-bit-per-stage pipeline.
// A stalled output holds every stage; in_ready is high when out_valid is low
// or out_ready is high. Reset (synchronous, rst_n low) clears all valid bits
// and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// boris_particle_push
// Fixed-point Boris push: half kick, rotation, half kick, move and wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module boris_particle_push import bpp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [W-1:0]        in_pos_x,
  input  logic [W-1:0]        in_pos_y,
  input  logic [W-1:0]        in_pos_z,
  input  logic signed [W-1:0] in_vel_x,
  input  logic signed [W-1:0] in_vel_y,
  input  logic signed [W-1:0] in_vel_z,
  input  logic signed [W-1:0] in_e_x,
  input  logic signed [W-1:0] in_e_y,
  input  logic signed [W-1:0] in_e_z,
  input  logic signed [W-1:0] in_b_x,
  input  logic signed [W-1:0] in_b_y,
  input  logic signed [W-1:0] in_b_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [W-1:0]        out_new_pos_x,
  output logic [W-1:0]        out_new_pos_y,
  output logic [W-1:0]        out_new_pos_z,
  output logic signed [W-1:0] out_new_vel_x,
  output logic signed [W-1:0] out_new_vel_y,
  output logic signed [W-1:0] out_new_vel_z,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [W-1:0]        cfg_data
);

  logic [W-2:0]      time_step_r;
  logic [W-1:0]      cmr_r;
  logic [2:0][W-1:0] len_r;

  logic              en;
  part_t             part;
  logic              fr_valid, dv_valid;
  side_t             fr_side, dv_side;
  dreq_t [2:0]       fr_req;
  logic [W-1:0]      fr_den;
  logic [2:0][QB-1:0] dv_quo;
  logic [2:0]        dv_neg;
  logic [2:0][W-1:0] res_pos;
  word_t [2:0]       res_vel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TS_RST;
      cmr_r       <= CMR_RST;
      len_r       <= {LEN_RST, LEN_RST, LEN_RST};
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TIME_STEP: time_step_r <= cfg_data[W-2:0];
        CFG_CMR:       cmr_r       <= cfg_data;
        CFG_LEN_X:     len_r[0]    <= cfg_data;
        CFG_LEN_Y:     len_r[1]    <= cfg_data;
        CFG_LEN_Z:     len_r[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign part.pos = {in_pos_z, in_pos_y, in_pos_x};
  assign part.vel = {in_vel_z, in_vel_y, in_vel_x};
  assign part.e   = {in_e_z, in_e_y, in_e_x};
  assign part.b   = {in_b_z, in_b_y, in_b_x};

  bpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_part   (part),
    .dt        (time_step_r),
    .cmr       (word_t'(cmr_r)),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_req   (fr_req),
    .out_den   (fr_den)
  );

  bpp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_req    (fr_req),
    .in_den    (fr_den),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_quo   (dv_quo),
    .out_neg   (dv_neg)
  );

  bpp_fin u_fin (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .in_side   (dv_side),
    .in_quo    (dv_quo),
    .in_neg    (dv_neg),
    .dt        (time_step_r),
    .len       (len_r),
    .out_valid (out_valid),
    .out_pos   (res_pos),
    .out_vel   (res_vel)
  );

  assign out_new_pos_x = res_pos[0];
  assign out_new_pos_y = res_pos[1];
  assign out_new_pos_z = res_pos[2];
  assign out_new_vel_x = res_vel[0];
  assign out_new_vel_y = res_vel[1];
  assign out_new_vel_z = res_vel[2];

endmodule

`default_nettype wire

// ===== src/bpp_front.sv =====
// ----------------------------------------------------------------------------
// bpp_front
// Half-step coefficient, first half kick, t vector, 1 + |t|^2 denominator and
// first rotation half. Eight register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_front import bpp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  part_t             in_part,
  input  logic [W-2:0]      dt,
  input  word_t             cmr,
  output logic              out_valid,
  output side_t             out_side,
  output dreq_t [2:0]       out_req,
  output logic [W-1:0]      out_den
);

  logic [7:0] vld_r;

  part_t             part1_r;
  mres_t             hm1_r;
  part_t             part2_r;
  word_t             h2_r;
  logic [2:0][W-1:0] pos3_r, pos4_r, pos5_r, pos6_r, pos7_r;
  word_t [2:0]       vel3_r, vel4_r;
  mres_t [2:0]       pe3_r, pb3_r, sq5_r, ca6_r, cb6_r;
  word_t [2:0]       he4_r, t4_r, vm5_r, he5_r, t5_r;
  word_t [2:0]       vm6_r, he6_r, t6_r, t2_6_r;
  word_t [2:0]       vm7_r, he7_r, t7_r, ca7_r, cb7_r;
  word_t             den7_r;
  side_t             side8_r;
  dreq_t [2:0]       req8_r;
  logic [W-1:0]      den8_r;

  word_t             den7_nxt;
  word_t [2:0]       vp8_nxt;
  dreq_t [2:0]       req8_nxt;

  always_comb begin
    den7_nxt = sat_s(SW'(ONE_C) + sx(t2_6_r[0]) + sx(t2_6_r[1]) + sx(t2_6_r[2]));
  end

  always_comb begin
    logic [W-1:0] tm;
    for (int i = 0; i < 3; i++) begin
      vp8_nxt[i] = sat_s(sx(vm7_r[i]) + sx(ca7_r[i]) - sx(cb7_r[i]));
      tm = t7_r[i][W-1] ? W'(-t7_r[i]) : W'(t7_r[i]);
      req8_nxt[i].nmag = {tm, 1'b0};
      req8_nxt[i].neg  = t7_r[i][W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part1_r <= in_part;
      hm1_r   <= fmul_mag(xw(cmr), $signed(XW'(dt)));

      part2_r <= part1_r;
      h2_r    <= rnd_sat(hm1_r, F + 1);

      pos3_r <= part2_r.pos;
      vel3_r <= part2_r.vel;
      for (int i = 0; i < 3; i++) begin
        pe3_r[i] <= fmul_mag(xw(h2_r), xw(part2_r.e[i]));
        pb3_r[i] <= fmul_mag(xw(h2_r), xw(part2_r.b[i]));
      end

      pos4_r <= pos3_r;
      vel4_r <= vel3_r;
      for (int i = 0; i < 3; i++) begin
        he4_r[i] <= rnd_sat(pe3_r[i], F);
        t4_r[i]  <= rnd_sat(pb3_r[i], F);
      end

      pos5_r <= pos4_r;
      he5_r  <= he4_r;
      t5_r   <= t4_r;
      for (int i = 0; i < 3; i++) begin
        vm5_r[i] <= sat_s(sx(vel4_r[i]) + sx(he4_r[i]));
        sq5_r[i] <= fmul_mag(xw(t4_r[i]), xw(t4_r[i]));
      end

      pos6_r <= pos5_r;
      vm6_r  <= vm5_r;
      he6_r  <= he5_r;
      t6_r   <= t5_r;
      for (int i = 0; i < 3; i++) begin
        t2_6_r[i] <= rnd_sat(sq5_r[i], F);
        ca6_r[i]  <= fmul_mag(xw(vm5_r[NXA[i]]), xw(t5_r[NXB[i]]));
        cb6_r[i]  <= fmul_mag(xw(vm5_r[NXB[i]]), xw(t5_r[NXA[i]]));
      end

      pos7_r  <= pos6_r;
      vm7_r   <= vm6_r;
      he7_r   <= he6_r;
      t7_r    <= t6_r;
      den7_r  <= den7_nxt;
      for (int i = 0; i < 3; i++) begin
        ca7_r[i] <= rnd_sat(ca6_r[i], F);
        cb7_r[i] <= rnd_sat(cb6_r[i], F);
      end

      side8_r.pos <= pos7_r;
      side8_r.vm  <= vm7_r;
      side8_r.he  <= he7_r;
      side8_r.vp  <= vp8_nxt;
      req8_r      <= req8_nxt;
      den8_r      <= den7_r;
    end
  end

  assign out_valid = vld_r[7];
  assign out_side  = side8_r;
  assign out_req   = req8_r;
  assign out_den   = den8_r;

endmodule

`default_nettype wire

// ===== src/bpp_div.sv =====
// ----------------------------------------------------------------------------
// bpp_div
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one denominator. Computes (|2t| << F) / den.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_div import bpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  side_t                 in_side,
  input  dreq_t [2:0]           in_req,
  input  logic [W-1:0]          in_den,
  output logic                  out_valid,
  output side_t                 out_side,
  output logic [2:0][QB-1:0]    out_quo,
  output logic [2:0]            out_neg
);

  typedef struct packed {
    logic [W-1:0]  rem;
    logic [QB-1:0] rest;
    logic [QB-1:0] quo;
    logic          neg;
  } dlane_t;

  typedef struct packed {
    logic [W-1:0]   den;
    dlane_t [2:0]   lane;
    side_t          side;
  } dstage_t;

  function automatic dlane_t div_step(dlane_t x, logic [W-1:0] den);
    logic [W:0] trial;
    logic       take;
    dlane_t     y;
    trial  = {x.rem, x.rest[QB-1]};
    take   = (trial >= {1'b0, den});
    y      = x;
    y.rem  = take ? W'(trial - {1'b0, den}) : trial[W-1:0];
    y.rest = {x.rest[QB-2:0], 1'b0};
    y.quo  = {x.quo[QB-2:0], take};
    return y;
  endfunction

  logic [QB-1:0] vld_r;
  dstage_t       stg_r   [QB];
  dstage_t       stg_nxt [QB];
  dstage_t       init_s;

  always_comb begin
    init_s.den  = in_den;
    init_s.side = in_side;
    for (int i = 0; i < 3; i++) begin
      init_s.lane[i].rem  = W'(in_req[i].nmag[W -: F]);
      init_s.lane[i].rest = {in_req[i].nmag[W-F:0], {F{1'b0}}};
      init_s.lane[i].quo  = '0;
      init_s.lane[i].neg  = in_req[i].neg;
    end
  end

  always_comb begin
    dstage_t src;
    for (int k = 0; k < QB; k++) begin
      if (k == 0) src = init_s;
      else src = stg_r[k-1];
      stg_nxt[k] = src;
      for (int i = 0; i < 3; i++) begin
        stg_nxt[k].lane[i] = div_step(src.lane[i], src.den);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QB-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[QB-1];
  assign out_side  = stg_r[QB-1].side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_quo[i] = stg_r[QB-1].lane[i].quo;
      out_neg[i] = stg_r[QB-1].lane[i].neg;
    end
  end

endmodule

`default_nettype wire

// ===== src/bpp_fin.sv =====
// ----------------------------------------------------------------------------
// bpp_fin
// Second rotation half, second half kick, position step and periodic wrap.
// Nine register stages, the last one is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_fin import bpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  side_t                 in_side,
  input  logic [2:0][QB-1:0]    in_quo,
  input  logic [2:0]            in_neg,
  input  logic [W-2:0]          dt,
  input  logic [2:0][W-1:0]     len,
  output logic                  out_valid,
  output logic [2:0][W-1:0]     out_pos,
  output word_t [2:0]           out_vel
);

  logic [8:0] vld_r;

  side_t             side1_r;
  xword_t [2:0]      s1_r;
  logic [2:0][W-1:0] pos2_r, pos3_r, pos4_r, pos5_r, pos6_r, pos7_r, pos9_r;
  word_t [2:0]       vm2_r, he2_r, vm3_r, he3_r, he4_r;
  mres_t [2:0]       ca2_r, cb2_r, st6_r;
  word_t [2:0]       ca3_r, cb3_r, vpl4_r, vn5_r, vn6_r, vn7_r, st7_r, vn8_r, vn9_r;
  sword_t [2:0]      p8_r;

  sword_t [2:0]      p8_nxt;
  logic [2:0][W-1:0] pos9_nxt;

  always_comb begin
    sword_t p;
    sword_t l;
    for (int i = 0; i < 3; i++) begin
      l = $signed(SW'(len[i]));
      p = $signed(SW'(pos7_r[i])) + sx(st7_r[i]);
      if (p < 0) p = p + l;
      else if (p >= l) p = p - l;
      p8_nxt[i] = p;
    end
  end

  always_comb begin
    sword_t l;
    for (int i = 0; i < 3; i++) begin
      l = $signed(SW'(len[i]));
      if (len[i] == '0) pos9_nxt[i] = '0;
      else if (p8_r[i] < 0) pos9_nxt[i] = '0;
      else if (p8_r[i] >= l) pos9_nxt[i] = W'(len[i] - 1'b1);
      else pos9_nxt[i] = p8_r[i][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= in_side;
      for (int i = 0; i < 3; i++) begin
        s1_r[i] <= in_neg[i] ? -$signed(XW'(in_quo[i])) : $signed(XW'(in_quo[i]));
      end

      pos2_r <= side1_r.pos;
      vm2_r  <= side1_r.vm;
      he2_r  <= side1_r.he;
      for (int i = 0; i < 3; i++) begin
        ca2_r[i] <= fmul_mag(xw(side1_r.vp[NXA[i]]), s1_r[NXB[i]]);
        cb2_r[i] <= fmul_mag(xw(side1_r.vp[NXB[i]]), s1_r[NXA[i]]);
      end

      pos3_r <= pos2_r;
      vm3_r  <= vm2_r;
      he3_r  <= he2_r;
      for (int i = 0; i < 3; i++) begin
        ca3_r[i] <= rnd_sat(ca2_r[i], F);
        cb3_r[i] <= rnd_sat(cb2_r[i], F);
      end

      pos4_r <= pos3_r;
      he4_r  <= he3_r;
      for (int i = 0; i < 3; i++) begin
        vpl4_r[i] <= sat_s(sx(vm3_r[i]) + sx(ca3_r[i]) - sx(cb3_r[i]));
      end

      pos5_r <= pos4_r;
      for (int i = 0; i < 3; i++) begin
        vn5_r[i] <= sat_s(sx(vpl4_r[i]) + sx(he4_r[i]));
      end

      pos6_r <= pos5_r;
      vn6_r  <= vn5_r;
      for (int i = 0; i < 3; i++) begin
        st6_r[i] <= fmul_mag(xw(vn5_r[i]), $signed(XW'(dt)));
      end

      pos7_r <= pos6_r;
      vn7_r  <= vn6_r;
      for (int i = 0; i < 3; i++) begin
        st7_r[i] <= rnd_sat(st6_r[i], F);
      end

      p8_r  <= p8_nxt;
      vn8_r <= vn7_r;

      pos9_r <= pos9_nxt;
      vn9_r  <= vn8_r;
    end
  end

  assign out_valid = vld_r[8];
  assign out_pos   = pos9_r;
  assign out_vel   = vn9_r;

endmodule

`default_nettype wire

// ===== src/bpp_checker.sv =====
// ----------------------------------------------------------------------------
// bpp_checker
// Port-level checks for boris_particle_push, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_checker import bpp_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [W-1:0]        in_pos_x,
  input logic [W-1:0]        in_pos_y,
  input logic [W-1:0]        in_pos_z,
  input logic signed [W-1:0] in_vel_x,
  input logic signed [W-1:0] in_vel_y,
  input logic signed [W-1:0] in_vel_z,
  input logic signed [W-1:0] in_e_x,
  input logic signed [W-1:0] in_e_y,
  input logic signed [W-1:0] in_e_z,
  input logic signed [W-1:0] in_b_x,
  input logic signed [W-1:0] in_b_y,
  input logic signed [W-1:0] in_b_z,
  input logic                out_valid,
  input logic                out_ready,
  input logic [W-1:0]        out_new_pos_x,
  input logic [W-1:0]        out_new_pos_y,
  input logic [W-1:0]        out_new_pos_z,
  input logic signed [W-1:0] out_new_vel_x,
  input logic signed [W-1:0] out_new_vel_y,
  input logic signed [W-1:0] out_new_vel_z
);

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input side only stalls when the output register is held
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_new_pos_x) && $stable(out_new_vel_x)
      && $stable(out_new_pos_y) && $stable(out_new_vel_y)
      && $stable(out_new_pos_z) && $stable(out_new_vel_z))
    else $error("result changed while stalled");

  // a waiting input item keeps valid and payload
  a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid
      && $stable(in_pos_x) && $stable(in_pos_y) && $stable(in_pos_z)
      && $stable(in_vel_x) && $stable(in_vel_y) && $stable(in_vel_z)
      && $stable(in_e_x) && $stable(in_e_y) && $stable(in_e_z)
      && $stable(in_b_x) && $stable(in_b_y) && $stable(in_b_z))
    else $error("input item changed while waiting");

endmodule

bind boris_particle_push bpp_checker u_bpp_checker (.*);

`default_nettype wire

// ===== tb/boris_particle_push_tb.sv =====
// ----------------------------------------------------------------------------
// boris_particle_push_tb
// Self-checking testbench for the fixed-point Boris push. Particle items are
// streamed through valid/ready with random idling on both sides. Each accepted
// item is run through a local predictor of the push and the result is checked
// field by field in order. The configuration is changed between phases while
// the block is idle, covering register extremes and ignored indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module boris_particle_push_tb;
  import bpp_pkg::*;

  localparam longint SMAX = (longint'(1) << (W - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint UNIT = longint'(1) << F;
  localparam int     DRAIN_CYCLES = W + 30;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     ITEMS_PER_PHASE = 300;

  typedef struct packed {
    logic [2:0][W-1:0] npos;
    logic [2:0][W-1:0] nvel;
  } push_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [W-1:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic signed [W-1:0] in_e_x = '0, in_e_y = '0, in_e_z = '0;
  logic signed [W-1:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [W-1:0] out_new_pos_x, out_new_pos_y, out_new_pos_z;
  logic signed [W-1:0] out_new_vel_x, out_new_vel_y, out_new_vel_z;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;

  // predictor copy of the registers
  logic [W-2:0] step_reg = TS_RST;
  logic [W-1:0] ratio_reg = CMR_RST;
  logic [W-1:0] len_reg [3] = '{LEN_RST, LEN_RST, LEN_RST};

  part_t     particle_q [$];
  push_res_t push_expect_q [$];
  part_t     cur_particle;
  int        in_idle_pct = 0;
  int        out_idle_pct = 0;
  int        n_errors = 0;
  int        n_checked = 0;
  int        n_cfg_writes = 0;
  int        cycle_cnt = 0;

  boris_particle_push dut (.*);

  always #2 clk = ~clk;

  function automatic longint clamp_w(longint x);
    if (x > SMAX) return SMAX;
    if (x < SMIN) return SMIN;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b, int sh);
    logic [127:0] ma, mb, pr;
    logic ng;
    ng = (a < 0) != (b < 0);
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    pr = (ma * mb + (128'd1 << (sh - 1))) >> sh;
    if (pr >= (128'd1 << (W - 1))) return ng ? SMIN : SMAX;
    return ng ? -longint'(pr[62:0]) : longint'(pr[62:0]);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    logic [127:0] mn, q;
    mn = (n < 0) ? 128'(-n) : 128'(n);
    q = (mn << F) / 128'(d);
    return (n < 0) ? -longint'(q[62:0]) : longint'(q[62:0]);
  endfunction

  function automatic logic [W-1:0] wrap_axis(logic [W-1:0] pos, longint stp,
                                             logic [W-1:0] len);
    longint l, p;
    l = longint'({32'b0, len});
    p = longint'({32'b0, pos}) + stp;
    if (l == 0) return '0;
    if (p < 0) p += l;
    else if (p >= l) p -= l;
    if (p < 0) p = 0;
    if (p >= l) p = l - 1;
    return p[W-1:0];
  endfunction

  function automatic push_res_t boris_predict(part_t pt);
    longint dt, h, t2, den, vplus;
    longint he [3], vm [3], t [3], s [3], vp [3], vn [3];
    int a, b;
    push_res_t r;
    dt = longint'({33'b0, step_reg});
    h = qmul(longint'($signed(ratio_reg)), dt, F + 1);
    for (int i = 0; i < 3; i++) begin
      he[i] = qmul(h, longint'(pt.e[i]), F);
      vm[i] = clamp_w(longint'(pt.vel[i]) + he[i]);
      t[i] = qmul(h, longint'(pt.b[i]), F);
    end
    t2 = qmul(t[0], t[0], F) + qmul(t[1], t[1], F) + qmul(t[2], t[2], F);
    den = clamp_w(UNIT + t2);
    for (int i = 0; i < 3; i++) s[i] = qdiv(2 * t[i], den);
    for (int i = 0; i < 3; i++) begin
      a = (i + 1) % 3;
      b = (i + 2) % 3;
      vp[i] = clamp_w(vm[i] + qmul(vm[a], t[b], F) - qmul(vm[b], t[a], F));
    end
    for (int i = 0; i < 3; i++) begin
      a = (i + 1) % 3;
      b = (i + 2) % 3;
      vplus = clamp_w(vm[i] + qmul(vp[a], s[b], F) - qmul(vp[b], s[a], F));
      vn[i] = clamp_w(vplus + he[i]);
    end
    for (int i = 0; i < 3; i++) begin
      r.npos[i] = wrap_axis(pt.pos[i], qmul(vn[i], dt, F), len_reg[i]);
      r.nvel[i] = vn[i][W-1:0];
    end
    return r;
  endfunction

  // mix of full-range, physical-scale and extreme values
  function automatic logic [W-1:0] rand_field();
    int m;
    m = $urandom_range(9);
    if (m < 3) return $urandom;
    if (m == 3) return W'($urandom_range(7)) ^ ($urandom_range(1) ? WMAX_C : WMIN_C);
    if (m == 4) return W'($signed(W'($urandom) >>> 16));
    return W'($signed(W'($urandom) >>> $urandom_range(22, 4)));
  endfunction

  function automatic part_t rand_particle();
    part_t pt;
    for (int i = 0; i < 3; i++) begin
      if (len_reg[i] != 0 && $urandom_range(9) != 0) pt.pos[i] = $urandom % len_reg[i];
      else pt.pos[i] = $urandom;
      pt.vel[i] = rand_field();
      pt.e[i] = rand_field();
      pt.b[i] = rand_field();
    end
    return pt;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    n_cfg_writes++;
    case (idx)
      CFG_TIME_STEP: step_reg = val[W-2:0];
      CFG_CMR:       ratio_reg = val;
      CFG_LEN_X:     len_reg[0] = val;
      CFG_LEN_Y:     len_reg[1] = val;
      CFG_LEN_Z:     len_reg[2] = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (particle_q.size() != 0 || in_valid || push_expect_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_random(int n);
    for (int k = 0; k < n; k++) particle_q.push_back(rand_particle());
  endtask

  task automatic load_directed();
    part_t pt;
    for (int k = 0; k < 20; k++) begin
      for (int i = 0; i < 3; i++) begin
        case (k % 5)
          0: begin pt.pos[i] = '0; pt.vel[i] = '0; pt.e[i] = '0; pt.b[i] = '0; end
          1: begin pt.pos[i] = len_reg[i] - 1; pt.vel[i] = WMAX_C;
                   pt.e[i] = WMAX_C; pt.b[i] = WMAX_C; end
          2: begin pt.pos[i] = '0; pt.vel[i] = WMIN_C;
                   pt.e[i] = WMIN_C; pt.b[i] = WMIN_C; end
          3: begin pt.pos[i] = '1; pt.vel[i] = (k & 1) ? WMAX_C : WMIN_C;
                   pt.e[i] = ONE_C; pt.b[i] = -ONE_C; end
          default: pt = rand_particle();
        endcase
      end
      particle_q.push_back(pt);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) push_expect_q.push_back(boris_predict(cur_particle));
      if (!in_valid || in_ready) begin
        if (particle_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          cur_particle = particle_q.pop_front();
          in_pos_x <= cur_particle.pos[0];
          in_pos_y <= cur_particle.pos[1];
          in_pos_z <= cur_particle.pos[2];
          in_vel_x <= cur_particle.vel[0];
          in_vel_y <= cur_particle.vel[1];
          in_vel_z <= cur_particle.vel[2];
          in_e_x <= cur_particle.e[0];
          in_e_y <= cur_particle.e[1];
          in_e_z <= cur_particle.e[2];
          in_b_x <= cur_particle.b[0];
          in_b_y <= cur_particle.b[1];
          in_b_z <= cur_particle.b[2];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    push_res_t want;
    logic [W-1:0] got [6];
    string fname [6];
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
      if (out_valid && out_ready) begin
        got = '{out_new_pos_x, out_new_pos_y, out_new_pos_z,
                out_new_vel_x, out_new_vel_y, out_new_vel_z};
        fname = '{"new_pos_x", "new_pos_y", "new_pos_z",
                  "new_vel_x", "new_vel_y", "new_vel_z"};
        if (push_expect_q.size() == 0) begin
          $error("unexpected result item");
          n_errors++;
        end else begin
          want = push_expect_q.pop_front();
          n_checked++;
          for (int i = 0; i < 6; i++) begin
            if (got[i] !== ((i < 3) ? want.npos[i] : want.nvel[i - 3])) begin
              $error("%s: expected %h, got %h", fname[i],
                     (i < 3) ? want.npos[i] : want.nvel[i - 3], got[i]);
              n_errors++;
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("boris_particle_push test failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      in_idle_pct = (ph < 2) ? 22 : (ph < 4) ? 51 : 0;
      out_idle_pct = (ph < 2) ? 51 : (ph < 4) ? 22 : 0;
      case (ph)
        1: begin
          write_reg(CFG_TIME_STEP, WMAX_C);
          write_reg(CFG_CMR, ONE_C);
          write_reg(CFG_LEN_X, '1);
          write_reg(CFG_LEN_Y, '1);
          write_reg(CFG_LEN_Z, '1);
          end_writes();
        end
        2: begin
          write_reg(CFG_TIME_STEP, 1);
          write_reg(CFG_CMR, WMIN_C);
          write_reg(CFG_LEN_X, 1);
          write_reg(CFG_LEN_Y, 1);
          write_reg(CFG_LEN_Z, 1);
          write_reg(3'd5, $urandom);
          write_reg(3'd6, $urandom);
          write_reg(3'd7, $urandom);
          end_writes();
        end
        3: begin
          write_reg(CFG_TIME_STEP, $urandom_range(1 << 26, 1));
          write_reg(CFG_CMR, $urandom);
          write_reg(CFG_LEN_X, '0);
          write_reg(CFG_LEN_Y, $urandom);
          write_reg(CFG_LEN_Z, $urandom_range(32'h2000_0000, 1));
          end_writes();
        end
        4: begin
          write_reg(CFG_TIME_STEP, ONE_C);
          write_reg(CFG_CMR, WMAX_C);
          write_reg(CFG_LEN_X, LEN_RST);
          write_reg(CFG_LEN_Y, ONE_C);
          write_reg(CFG_LEN_Z, LEN_RST << 2);
          end_writes();
        end
        5: begin
          write_reg(CFG_TIME_STEP, TS_RST);
          write_reg(CFG_CMR, W'($signed(W'($urandom) >>> 6)));
          write_reg(CFG_LEN_X, LEN_RST);
          write_reg(CFG_LEN_Y, LEN_RST << 1);
          write_reg(CFG_LEN_Z, LEN_RST << 2);
          end_writes();
        end
        default: ;
      endcase
      load_directed();
      load_random(ITEMS_PER_PHASE);
      wait_idle();
    end
    $display("checked %0d particle results over 6 register settings, %0d register writes",
             n_checked, n_cfg_writes);
    if (n_errors == 0) begin
      $display("boris_particle_push test passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("boris_particle_push test failed");
    end
    $finish;
  end

endmodule
